>>> rtl/rv32ie_pkg.sv
// ----------------------------------------------------------------------------
// rv32ie_pkg
// shared types, codes and memory geometry of the rv32i execute unit
// ----------------------------------------------------------------------------
`default_nettype none

package rv32ie_pkg;

    // data memory geometry
    localparam int unsigned MEM_BYTES  = 65536;
    localparam int unsigned MEM_ROWS   = (MEM_BYTES + 3) / 4;
    localparam int unsigned MEM_ADDR_W = $clog2(MEM_BYTES);
    localparam int unsigned MEM_ROW_W  = $clog2(MEM_ROWS);

    // highest legal start address for each access size
    localparam logic [31:0] LIMIT_BYTE = 32'(MEM_BYTES - 1);
    localparam logic [31:0] LIMIT_HALF = 32'(MEM_BYTES - 2);
    localparam logic [31:0] LIMIT_WORD = 32'(MEM_BYTES - 4);

    localparam int unsigned REG_COUNT = 32;

    // opcode classes
    localparam logic [3:0] OPC_LUI    = 4'd0;
    localparam logic [3:0] OPC_AUIPC  = 4'd1;
    localparam logic [3:0] OPC_JAL    = 4'd2;
    localparam logic [3:0] OPC_JALR   = 4'd3;
    localparam logic [3:0] OPC_BRANCH = 4'd4;
    localparam logic [3:0] OPC_LOAD   = 4'd5;
    localparam logic [3:0] OPC_STORE  = 4'd6;
    localparam logic [3:0] OPC_OPIMM  = 4'd7;
    localparam logic [3:0] OPC_OP     = 4'd8;
    localparam logic [3:0] OPC_SYSTEM = 4'd9;

    // branch funct3
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // load and store funct3
    localparam logic [2:0] F3_LB  = 3'd0;
    localparam logic [2:0] F3_LH  = 3'd1;
    localparam logic [2:0] F3_LW  = 3'd2;
    localparam logic [2:0] F3_LBU = 3'd4;
    localparam logic [2:0] F3_LHU = 3'd5;
    localparam logic [2:0] F3_SB  = 3'd0;
    localparam logic [2:0] F3_SH  = 3'd1;
    localparam logic [2:0] F3_SW  = 3'd2;

    // alu funct3
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // access size, coded as index of the last byte
    localparam logic [1:0] LAST_BYTE = 2'd0;
    localparam logic [1:0] LAST_HALF = 2'd1;
    localparam logic [1:0] LAST_WORD = 2'd3;

    // environment call codes and their registers
    localparam logic [31:0] ECALL_PRINT_INT  = 32'd1;
    localparam logic [31:0] ECALL_EXIT       = 32'd10;
    localparam logic [31:0] ECALL_PRINT_CHAR = 32'd11;
    localparam logic [31:0] ECALL_EXIT_CODE  = 32'd17;
    localparam logic [4:0]  REG_A0 = 5'd10;
    localparam logic [4:0]  REG_A7 = 5'd17;

    // result status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ILLEGAL = 2'd1;
    localparam logic [1:0] ST_FAULT   = 2'd2;
    localparam logic [1:0] ST_HALTED  = 2'd3;

    // console kind
    localparam logic [1:0] CON_NONE = 2'd0;
    localparam logic [1:0] CON_INT  = 2'd1;
    localparam logic [1:0] CON_CHAR = 2'd2;

    typedef struct packed {
        logic        command;
        logic [3:0]  opcode_class;
        logic [2:0]  funct3;
        logic        alternate_bit;
        logic [4:0]  dest_reg;
        logic [4:0]  source_reg_one;
        logic [4:0]  source_reg_two;
        logic [31:0] immediate;
        logic [13:0] preload_word_index;
        logic [31:0] preload_data;
    } item_t;

    typedef struct packed {
        logic                  rd;
        logic                  wr;
        logic [MEM_ADDR_W-1:0] addr;
        logic [1:0]            last_byte;
        logic [2:0]            funct3;
        logic [31:0]           wdata;
    } mem_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] npc;
        logic [31:0] faddr;
        logic [1:0]  ckind;
        logic [31:0] cval;
        logic        wr;
        logic [31:0] wval;
        logic        is_load;
        logic        halt_set;
        logic        exit_set;
    } exec_res_t;

    typedef struct packed {
        logic        en;
        logic [4:0]  addr;
        logic [31:0] data;
    } rf_wr_t;

endpackage

`default_nettype wire

>>> rtl/rv32ie_ram.sv
// ----------------------------------------------------------------------------
// rv32ie_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module rv32ie_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/rv32ie_regfile.sv
// ----------------------------------------------------------------------------
// rv32ie_regfile
// 32 x 32 register file, two registered read ports that track later writes
// ----------------------------------------------------------------------------
`default_nettype none

module rv32ie_regfile (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                rd_en,
    input  wire logic [4:0]          raddr1,
    input  wire logic [4:0]          raddr2,
    input  wire rv32ie_pkg::rf_wr_t  wr,
    output logic      [31:0]         rdata1,
    output logic      [31:0]         rdata2
);

    logic [31:0] q1;
    logic [31:0] q2;
    logic [31:0] valid_reg;
    logic [4:0]  addr1_reg;
    logic [4:0]  addr2_reg;
    logic [4:0]  src1;
    logic [4:0]  src2;
    logic        vld1_reg;
    logic        vld2_reg;
    logic        use1_reg;
    logic        use2_reg;
    logic [31:0] fix1_reg;
    logic [31:0] fix2_reg;

    rv32ie_ram #(
        .WIDTH (32),
        .DEPTH (rv32ie_pkg::REG_COUNT)
    ) u_bank1 (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd_en),
        .raddr (raddr1),
        .rdata (q1)
    );

    rv32ie_ram #(
        .WIDTH (32),
        .DEPTH (rv32ie_pkg::REG_COUNT)
    ) u_bank2 (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd_en),
        .raddr (raddr2),
        .rdata (q2)
    );

    // address the held read belongs to, new one on a read
    assign src1 = rd_en ? raddr1 : addr1_reg;
    assign src2 = rd_en ? raddr2 : addr2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            addr1_reg <= '0;
            addr2_reg <= '0;
            vld1_reg  <= 1'b0;
            vld2_reg  <= 1'b0;
            use1_reg  <= 1'b0;
            use2_reg  <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                addr1_reg <= raddr1;
                addr2_reg <= raddr2;
                vld1_reg  <= valid_reg[raddr1];
                vld2_reg  <= valid_reg[raddr2];
            end
            // a write landing after the array read overrides the read data
            if (wr.en && wr.addr == src1)
            begin
                use1_reg <= 1'b1;
            end
            else if (rd_en)
            begin
                use1_reg <= 1'b0;
            end
            if (wr.en && wr.addr == src2)
            begin
                use2_reg <= 1'b1;
            end
            else if (rd_en)
            begin
                use2_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && wr.addr == src1)
        begin
            fix1_reg <= wr.data;
        end
        if (wr.en && wr.addr == src2)
        begin
            fix2_reg <= wr.data;
        end
    end

    assign rdata1 = use1_reg ? fix1_reg : (vld1_reg ? q1 : 32'd0);
    assign rdata2 = use2_reg ? fix2_reg : (vld2_reg ? q2 : 32'd0);

endmodule

`default_nettype wire

>>> rtl/rv32ie_dmem.sv
// ----------------------------------------------------------------------------
// rv32ie_dmem
// byte-lane data memory with unaligned access and load formatting
// ----------------------------------------------------------------------------
`default_nettype none

module rv32ie_dmem (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire rv32ie_pkg::mem_req_t  req,
    output logic      [31:0]           load_value
);

    logic [1:0]                       off;
    logic [rv32ie_pkg::MEM_ROW_W-1:0] row;
    logic [31:0]                      wrot;
    logic [31:0]                      lanes;
    logic [31:0]                      word;
    logic [1:0]                       off_reg;
    logic [2:0]                       f3_reg;
    logic                             rd_go;

    function automatic logic [31:0] rot_left(input logic [31:0] x, input logic [1:0] n);
        logic [31:0] r;
        case (n)
            2'd0:    r = x;
            2'd1:    r = {x[23:0], x[31:24]};
            2'd2:    r = {x[15:0], x[31:16]};
            2'd3:    r = {x[7:0], x[31:8]};
            default: r = x;
        endcase
        return r;
    endfunction

    assign off   = req.addr[1:0];
    assign row   = req.addr[rv32ie_pkg::MEM_ADDR_W-1:2];
    assign wrot  = rot_left(req.wdata, off);
    assign rd_go = en && req.rd;

    for (genvar l = 0; l < 4; l++)
    begin : g_lane
        logic [1:0]                       lane_off;
        logic [rv32ie_pkg::MEM_ROW_W-1:0] lane_row;
        logic                             lane_we;

        // lanes below the start offset hold bytes of the following row
        assign lane_off = 2'(l) - off;
        assign lane_row = row + {{(rv32ie_pkg::MEM_ROW_W-1){1'b0}}, (2'(l) < off)};
        assign lane_we  = en && req.wr && (lane_off <= req.last_byte);

        rv32ie_ram #(
            .WIDTH (8),
            .DEPTH (rv32ie_pkg::MEM_ROWS)
        ) u_lane (
            .clk   (clk),
            .we    (lane_we),
            .waddr (lane_row),
            .wdata (wrot[8*l +: 8]),
            .re    (rd_go),
            .raddr (lane_row),
            .rdata (lanes[8*l +: 8])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg <= '0;
            f3_reg  <= '0;
        end
        else if (rd_go)
        begin
            off_reg <= off;
            f3_reg  <= req.funct3;
        end
    end

    // undo the lane rotation: byte 0 of the access sits at lane off
    assign word = rot_left(lanes, 2'd0 - off_reg);

    always_comb
    begin
        case (f3_reg)
            rv32ie_pkg::F3_LB:  load_value = {{24{word[7]}}, word[7:0]};
            rv32ie_pkg::F3_LH:  load_value = {{16{word[15]}}, word[15:0]};
            rv32ie_pkg::F3_LBU: load_value = {24'd0, word[7:0]};
            rv32ie_pkg::F3_LHU: load_value = {16'd0, word[15:0]};
            default:            load_value = word;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/rv32ie_exec.sv
// ----------------------------------------------------------------------------
// rv32ie_exec
// combinational execute logic: alu, branch, address, bounds and ecall decode
// ----------------------------------------------------------------------------
`default_nettype none

module rv32ie_exec (
    input  wire rv32ie_pkg::item_t      item,
    input  wire logic [31:0]            opa,
    input  wire logic [31:0]            opb,
    input  wire logic [31:0]            pc,
    input  wire logic                   halted,
    output rv32ie_pkg::exec_res_t       res,
    output rv32ie_pkg::mem_req_t        mreq
);

    logic [31:0] addr;
    logic [31:0] target;
    logic [31:0] upper;
    logic [31:0] pre_addr;
    logic [31:0] y;
    logic [4:0]  shamt;
    logic [31:0] alu;
    logic        taken;
    logic        ok;

    assign addr     = opa + item.immediate;
    assign target   = pc + item.immediate;
    assign upper    = {item.immediate[19:0], 12'd0};
    assign pre_addr = {16'd0, item.preload_word_index, 2'b00};
    assign y        = (item.opcode_class == rv32ie_pkg::OPC_OP) ? opb : item.immediate;
    assign shamt    = y[4:0];

    always_comb
    begin
        case (item.funct3)
            rv32ie_pkg::F3_ADD:
                alu = (item.opcode_class == rv32ie_pkg::OPC_OP && item.alternate_bit)
                      ? opa - y : opa + y;
            rv32ie_pkg::F3_SLL:  alu = opa << shamt;
            rv32ie_pkg::F3_SLT:  alu = {31'd0, $signed(opa) < $signed(y)};
            rv32ie_pkg::F3_SLTU: alu = {31'd0, opa < y};
            rv32ie_pkg::F3_XOR:  alu = opa ^ y;
            rv32ie_pkg::F3_SR:
                alu = item.alternate_bit ? 32'($signed(opa) >>> shamt) : opa >> shamt;
            rv32ie_pkg::F3_OR:   alu = opa | y;
            default:             alu = opa & y;
        endcase
    end

    always_comb
    begin
        case (item.funct3)
            rv32ie_pkg::F3_BEQ:  taken = opa == opb;
            rv32ie_pkg::F3_BNE:  taken = opa != opb;
            rv32ie_pkg::F3_BLT:  taken = $signed(opa) < $signed(opb);
            rv32ie_pkg::F3_BGE:  taken = !($signed(opa) < $signed(opb));
            rv32ie_pkg::F3_BLTU: taken = opa < opb;
            rv32ie_pkg::F3_BGEU: taken = opa >= opb;
            default:             taken = 1'b0;
        endcase
    end

    always_comb
    begin
        res            = '0;
        res.status     = rv32ie_pkg::ST_OK;
        res.ckind      = rv32ie_pkg::CON_NONE;
        res.npc        = pc + 32'd4;
        mreq           = '0;
        mreq.addr      = addr[rv32ie_pkg::MEM_ADDR_W-1:0];
        mreq.wdata     = opb;
        mreq.funct3    = item.funct3;
        mreq.last_byte = rv32ie_pkg::LAST_WORD;
        ok             = 1'b0;

        if (item.command)
        begin
            // preload: whole word or nothing
            res.npc    = pc;
            mreq.addr  = pre_addr[rv32ie_pkg::MEM_ADDR_W-1:0];
            mreq.wdata = item.preload_data;
            mreq.wr    = pre_addr <= rv32ie_pkg::LIMIT_WORD;
        end
        else if (halted)
        begin
            res.status = rv32ie_pkg::ST_HALTED;
            res.npc    = pc;
        end
        else
        begin
            case (item.opcode_class)
                rv32ie_pkg::OPC_LUI:
                begin
                    res.wr   = 1'b1;
                    res.wval = upper;
                end
                rv32ie_pkg::OPC_AUIPC:
                begin
                    res.wr   = 1'b1;
                    res.wval = pc + upper;
                end
                rv32ie_pkg::OPC_JAL:
                begin
                    res.wr   = 1'b1;
                    res.wval = pc + 32'd4;
                    res.npc  = target;
                end
                rv32ie_pkg::OPC_JALR:
                begin
                    res.wr   = 1'b1;
                    res.wval = pc + 32'd4;
                    res.npc  = {addr[31:1], 1'b0};
                end
                rv32ie_pkg::OPC_BRANCH:
                begin
                    if (taken)
                    begin
                        res.npc = target;
                    end
                end
                rv32ie_pkg::OPC_LOAD:
                begin
                    case (item.funct3)
                        rv32ie_pkg::F3_LB, rv32ie_pkg::F3_LBU:
                        begin
                            mreq.last_byte = rv32ie_pkg::LAST_BYTE;
                            ok             = addr <= rv32ie_pkg::LIMIT_BYTE;
                        end
                        rv32ie_pkg::F3_LH, rv32ie_pkg::F3_LHU:
                        begin
                            mreq.last_byte = rv32ie_pkg::LAST_HALF;
                            ok             = addr <= rv32ie_pkg::LIMIT_HALF;
                        end
                        rv32ie_pkg::F3_LW:
                        begin
                            ok = addr <= rv32ie_pkg::LIMIT_WORD;
                        end
                        default:
                        begin
                            ok = 1'b0;
                        end
                    endcase
                    if (ok)
                    begin
                        mreq.rd     = 1'b1;
                        res.wr      = 1'b1;
                        res.is_load = 1'b1;
                    end
                    else
                    begin
                        res.status = rv32ie_pkg::ST_FAULT;
                        res.faddr  = addr;
                        res.npc    = pc;
                    end
                end
                rv32ie_pkg::OPC_STORE:
                begin
                    case (item.funct3)
                        rv32ie_pkg::F3_SB:
                        begin
                            mreq.last_byte = rv32ie_pkg::LAST_BYTE;
                            ok             = addr <= rv32ie_pkg::LIMIT_BYTE;
                        end
                        rv32ie_pkg::F3_SH:
                        begin
                            mreq.last_byte = rv32ie_pkg::LAST_HALF;
                            ok             = addr <= rv32ie_pkg::LIMIT_HALF;
                        end
                        rv32ie_pkg::F3_SW:
                        begin
                            ok = addr <= rv32ie_pkg::LIMIT_WORD;
                        end
                        default:
                        begin
                            ok = 1'b0;
                        end
                    endcase
                    if (ok)
                    begin
                        mreq.wr = 1'b1;
                    end
                    else
                    begin
                        res.status = rv32ie_pkg::ST_FAULT;
                        res.faddr  = addr;
                        res.npc    = pc;
                    end
                end
                rv32ie_pkg::OPC_OPIMM, rv32ie_pkg::OPC_OP:
                begin
                    res.wr   = 1'b1;
                    res.wval = alu;
                end
                rv32ie_pkg::OPC_SYSTEM:
                begin
                    // operands carry a0 and a7 for this class
                    if (opb == rv32ie_pkg::ECALL_PRINT_INT)
                    begin
                        res.ckind = rv32ie_pkg::CON_INT;
                        res.cval  = opa;
                    end
                    else if (opb == rv32ie_pkg::ECALL_PRINT_CHAR)
                    begin
                        res.ckind = rv32ie_pkg::CON_CHAR;
                        res.cval  = opa;
                    end
                    else if (opb == rv32ie_pkg::ECALL_EXIT)
                    begin
                        res.halt_set = 1'b1;
                        res.status   = rv32ie_pkg::ST_HALTED;
                        res.npc      = pc;
                    end
                    else if (opb == rv32ie_pkg::ECALL_EXIT_CODE)
                    begin
                        res.halt_set = 1'b1;
                        res.exit_set = 1'b1;
                        res.status   = rv32ie_pkg::ST_HALTED;
                        res.npc      = pc;
                    end
                end
                default:
                begin
                    res.status = rv32ie_pkg::ST_ILLEGAL;
                    res.npc    = pc;
                end
            endcase
        end

        // x0 is never written
        if (!(res.wr && item.dest_reg != 5'd0))
        begin
            res.wr      = 1'b0;
            res.wval    = 32'd0;
            res.is_load = 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rv32i_execute_unit_top.sv
// ----------------------------------------------------------------------------
// rv32i_execute_unit_top
// executes one decoded rv32i instruction or one memory preload per beat
// ----------------------------------------------------------------------------
//
//  channel  | valid         | stall         | payload
//  ---------+---------------+---------------+-----------------------------------
//  item     | item_valid    | item_stall    | command .. preload_data
//  result   | result_valid  | result_stall  | status .. written_value
//
//  one beat per cycle sustained while the result is not stalled; an item
//  leaves as a result after the regfile read, then execute into the result register
//  the loop that bounds the rate is the execute stage: forwarded operand,
//  address add, bounds compare and the data memory port, all in the same cycle
//  reset clears pc, halt, exit code and the regfile valid bits; data memory
//  holds no reset value and needs no clearing pass
//  a stalled result holds the execute stage, which in turn stalls item
//
`default_nettype none

module rv32i_execute_unit_top (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic        command,
    input  wire logic [3:0]  opcode_class,
    input  wire logic [2:0]  funct3,
    input  wire logic        alternate_bit,
    input  wire logic [4:0]  dest_reg,
    input  wire logic [4:0]  source_reg_one,
    input  wire logic [4:0]  source_reg_two,
    input  wire logic [31:0] immediate,
    input  wire logic [13:0] preload_word_index,
    input  wire logic [31:0] preload_data,

    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [1:0]       status,
    output logic [31:0]      next_pc,
    output logic [31:0]      fault_address,
    output logic [31:0]      exit_value,
    output logic [1:0]       console_kind,
    output logic [31:0]      console_value,
    output logic             reg_written,
    output logic [31:0]      written_value
);

    // item beat accepted this cycle
    logic                  in_acc;
    // execute stage moves into the result register this cycle
    logic                  ex_adv;

    rv32ie_pkg::item_t     in_item;
    rv32ie_pkg::item_t     ex_item_reg;
    logic                  ex_valid_reg;

    // regfile read addresses: environment calls read a0 and a7
    logic [4:0]            rf_raddr1;
    logic [4:0]            rf_raddr2;
    logic [4:0]            ex_src1;
    logic [4:0]            ex_src2;
    logic [31:0]           rf_rdata1;
    logic [31:0]           rf_rdata2;
    logic [31:0]           opa;
    logic [31:0]           opb;

    // architectural state
    logic [31:0]           pc_reg;
    logic                  halted_reg;
    logic [31:0]           exit_reg;
    logic [31:0]           exit_next;

    rv32ie_pkg::exec_res_t res;
    rv32ie_pkg::mem_req_t  mreq;
    logic [31:0]           load_value;

    // writeback stage, in the cycle after execute so load data can land
    logic                  wb_pend_reg;
    logic [4:0]            wb_rd_reg;
    logic                  wb_load_reg;
    logic [31:0]           wb_val_reg;
    logic [31:0]           wb_data;
    rv32ie_pkg::rf_wr_t    rf_wr;

    // result register
    logic                  result_valid_reg;
    logic [1:0]            status_reg;
    logic [31:0]           npc_reg;
    logic [31:0]           faddr_reg;
    logic [31:0]           exit_out_reg;
    logic [1:0]            ckind_reg;
    logic [31:0]           cval_reg;
    logic                  wr_reg;
    logic                  out_load_reg;
    logic [31:0]           wval_reg;

    assign in_item = '{
        command:            command,
        opcode_class:       opcode_class,
        funct3:             funct3,
        alternate_bit:      alternate_bit,
        dest_reg:           dest_reg,
        source_reg_one:     source_reg_one,
        source_reg_two:     source_reg_two,
        immediate:          immediate,
        preload_word_index: preload_word_index,
        preload_data:       preload_data
    };

    // handshake: execute drains whenever the result register is free or leaving
    assign ex_adv     = ex_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = ex_valid_reg && !ex_adv;
    assign in_acc     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            ex_valid_reg <= 1'b1;
        end
        else if (ex_adv)
        begin
            ex_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ex_item_reg <= in_item;
        end
    end

    // register file read happens on the accepting edge
    assign rf_raddr1 = (opcode_class == rv32ie_pkg::OPC_SYSTEM) ? rv32ie_pkg::REG_A0
                                                                : source_reg_one;
    assign rf_raddr2 = (opcode_class == rv32ie_pkg::OPC_SYSTEM) ? rv32ie_pkg::REG_A7
                                                                : source_reg_two;
    assign ex_src1   = (ex_item_reg.opcode_class == rv32ie_pkg::OPC_SYSTEM)
                       ? rv32ie_pkg::REG_A0 : ex_item_reg.source_reg_one;
    assign ex_src2   = (ex_item_reg.opcode_class == rv32ie_pkg::OPC_SYSTEM)
                       ? rv32ie_pkg::REG_A7 : ex_item_reg.source_reg_two;

    rv32ie_regfile u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (in_acc),
        .raddr1 (rf_raddr1),
        .raddr2 (rf_raddr2),
        .wr     (rf_wr),
        .rdata1 (rf_rdata1),
        .rdata2 (rf_rdata2)
    );

    // forward the pending writeback (only ever to a nonzero register)
    assign wb_data = wb_load_reg ? load_value : wb_val_reg;
    assign opa     = (wb_pend_reg && wb_rd_reg == ex_src1) ? wb_data : rf_rdata1;
    assign opb     = (wb_pend_reg && wb_rd_reg == ex_src2) ? wb_data : rf_rdata2;

    rv32ie_exec u_exec (
        .item   (ex_item_reg),
        .opa    (opa),
        .opb    (opb),
        .pc     (pc_reg),
        .halted (halted_reg),
        .res    (res),
        .mreq   (mreq)
    );

    // data memory acts only on the advancing edge, so its read data holds
    // for as long as the result waits
    rv32ie_dmem u_dmem (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (ex_adv),
        .req        (mreq),
        .load_value (load_value)
    );

    assign exit_next = res.exit_set ? opa : exit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= 32'd0;
            halted_reg <= 1'b0;
            exit_reg   <= 32'd0;
        end
        else if (ex_adv)
        begin
            pc_reg     <= res.npc;
            halted_reg <= halted_reg || res.halt_set;
            exit_reg   <= exit_next;
        end
    end

    // writeback: one regfile write per cycle at most
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_pend_reg <= 1'b0;
            wb_rd_reg   <= 5'd0;
            wb_load_reg <= 1'b0;
        end
        else
        begin
            wb_pend_reg <= ex_adv && res.wr;
            if (ex_adv)
            begin
                wb_rd_reg   <= ex_item_reg.dest_reg;
                wb_load_reg <= res.is_load;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ex_adv)
        begin
            wb_val_reg <= res.wval;
        end
    end

    assign rf_wr = '{en: wb_pend_reg, addr: wb_rd_reg, data: wb_data};

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (ex_adv)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ex_adv)
        begin
            status_reg   <= res.status;
            npc_reg      <= res.npc;
            faddr_reg    <= res.faddr;
            exit_out_reg <= exit_next;
            ckind_reg    <= res.ckind;
            cval_reg     <= res.cval;
            wr_reg       <= res.wr;
            out_load_reg <= res.is_load;
            wval_reg     <= res.wval;
        end
    end

    assign result_valid  = result_valid_reg;
    assign status        = status_reg;
    assign next_pc       = npc_reg;
    assign fault_address = faddr_reg;
    assign exit_value    = exit_out_reg;
    assign console_kind  = ckind_reg;
    assign console_value = cval_reg;
    assign reg_written   = wr_reg;
    assign written_value = out_load_reg ? load_value : wval_reg;

    // a writeback only ever follows an execute advance
    a_wb_after_adv: assert property (@(posedge clk) disable iff (!rst_n)
        wb_pend_reg |-> $past(ex_adv))
        else $error("writeback pending without an execute advance");

    // once halted, stays halted
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared");

    // pc only moves when an item leaves execute
    a_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ex_adv |=> $stable(pc_reg))
        else $error("pc changed without an execute advance");

    // a halted result implies the halt flag is set
    a_halt_status: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && status_reg == rv32ie_pkg::ST_HALTED) |-> halted_reg)
        else $error("halted status while running");

endmodule

`default_nettype wire
